@@ rtl/socks5_client_handshake_assert.svh @@
// assertion macros used by the checker file
`ifndef SOCKS5_CLIENT_HANDSHAKE_ASSERT_SVH
`define SOCKS5_CLIENT_HANDSHAKE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define S5CH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("socks5 handshake check failed");

// next-cycle implication, disabled in reset
`define S5CH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("socks5 handshake check failed");

`endif

@@ rtl/s5ch_pkg.sv @@
// types and constants of the socks5 client handshake
package s5ch_pkg;

  // input operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_EOF   = 2'd3;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_REQ_PW    = 3'd0;
  localparam logic [2:0] CFG_DEST_ADDR = 3'd1;
  localparam logic [2:0] CFG_DEST_PORT = 3'd2;
  localparam logic [2:0] CFG_USER_LEN  = 3'd3;
  localparam logic [2:0] CFG_PASS_LEN  = 3'd4;

  // status codes
  localparam logic [4:0] ST_OK          = 5'd0;
  localparam logic [4:0] ST_EOF         = 5'd1;
  localparam logic [4:0] ST_BAD_LEN     = 5'd2;
  localparam logic [4:0] ST_NOT_SOCKS5  = 5'd3;
  localparam logic [4:0] ST_UNK_METHOD  = 5'd4;
  localparam logic [4:0] ST_ANON_ONLY   = 5'd5;
  localparam logic [4:0] ST_AUTH_REFUSE = 5'd6;
  localparam logic [4:0] ST_AUTH_REQ    = 5'd7;
  localparam logic [4:0] ST_BAD_AUTHVER = 5'd8;
  localparam logic [4:0] ST_AUTH_FAIL   = 5'd9;
  localparam logic [4:0] ST_REPLY_BASE  = 5'd9;
  localparam logic [4:0] ST_UNK_REPLY   = 5'd18;
  localparam logic [4:0] ST_NOT_IPV4    = 5'd19;
  localparam logic [4:0] ST_BAD_LEN_CON = 5'd20;
  localparam logic [4:0] ST_CONNECTED   = 5'd21;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] AUTH_VER    = 8'h01;
  localparam logic [7:0] N_METHODS   = 8'h01;
  localparam logic [7:0] METH_NONE   = 8'h00;
  localparam logic [7:0] METH_PASS   = 8'h02;
  localparam logic [7:0] METH_REJECT = 8'hFF;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] RSV_BYTE    = 8'h00;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] AUTH_OK     = 8'h00;
  localparam logic [7:0] REP_MAX     = 8'h08;

  localparam int CRED_SLOT = 16;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] cred_index;
    logic [7:0] data_byte;
    logic       read_end;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_data;
    logic       last;
    logic [4:0] status;
  } out_item_t;

  // steps of the request run
  typedef enum logic [4:0] {
    E_VER, E_NMETH, E_METH, E_AUTHVER, E_ULEN, E_UBYTE, E_PLEN, E_PBYTE,
    E_CVER, E_CCMD, E_RSV, E_ATYP, E_A3, E_A2, E_A1, E_A0, E_P1, E_P0
  } emit_step_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       emit;
    emit_step_t step;
    logic [3:0] cnt;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic       need_pw;
    logic [4:0] ulen;
    logic [4:0] plen;
  } dp_stat_t;

endpackage

@@ rtl/s5ch_ctrl.sv @@
// controller: input acceptance and request run sequencing
module s5ch_ctrl
  import s5ch_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] operation,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t     state;
  emit_step_t step;
  logic [3:0] cnt;
  logic [4:0] cnt_inc;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign cnt_inc  = {1'b0, cnt} + 5'd1;

  assign cmd.accept = in_valid && in_ready;
  assign cmd.emit   = (state == S_EMIT) && stat.out_free;
  assign cmd.step   = step;
  assign cmd.cnt    = cnt;

  // state and run step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= E_VER;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept && operation == OP_START) begin
            state <= S_EMIT;
            step  <= E_VER;
            cnt   <= '0;
          end
        end
        S_EMIT: begin
          if (cmd.emit) begin
            unique case (step)
              E_VER:     step <= E_NMETH;
              E_NMETH:   step <= E_METH;
              E_METH:    step <= stat.need_pw ? E_AUTHVER : E_CVER;
              E_AUTHVER: step <= E_ULEN;
              E_ULEN: begin
                cnt  <= '0;
                step <= (stat.ulen == 5'd0) ? E_PLEN : E_UBYTE;
              end
              E_UBYTE: begin
                if (cnt_inc == stat.ulen) begin
                  step <= E_PLEN;
                end else begin
                  cnt <= cnt_inc[3:0];
                end
              end
              E_PLEN: begin
                cnt  <= '0;
                step <= (stat.plen == 5'd0) ? E_CVER : E_PBYTE;
              end
              E_PBYTE: begin
                if (cnt_inc == stat.plen) begin
                  step <= E_CVER;
                end else begin
                  cnt <= cnt_inc[3:0];
                end
              end
              E_CVER:  step <= E_CCMD;
              E_CCMD:  step <= E_RSV;
              E_RSV:   step <= E_ATYP;
              E_ATYP:  step <= E_A3;
              E_A3:    step <= E_A2;
              E_A2:    step <= E_A1;
              E_A1:    step <= E_A0;
              E_A0:    step <= E_P1;
              E_P1:    step <= E_P0;
              E_P0:    state <= S_IDLE;
              default: state <= S_IDLE;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/s5ch_dpath.sv @@
// datapath: registers, credential store, reply gathering and judging, output beat
module s5ch_dpath
  import s5ch_pkg::*;
#(
  parameter int CRED_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam logic [4:0] CRED_EFF = 5'((CRED_MAX < CRED_SLOT) ? CRED_MAX : CRED_SLOT);

  typedef enum logic [2:0] {
    PH_IDLE, PH_METHOD, PH_AUTH, PH_CONNECT, PH_CONNECTED, PH_CLOSED
  } phase_t;

  logic        require_password;
  logic [31:0] dest_address;
  logic [15:0] dest_port;
  logic [4:0]  user_length;
  logic [4:0]  pass_length;

  logic [7:0]  cred_mem [32];

  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  rcount;
  logic [7:0]  rb0, rb1, rb3;

  logic [4:0]  ulen_c, plen_c;
  logic [7:0]  tx_byte;
  logic [3:0]  size_full, cnt_after;
  logic [7:0]  b0e, b1e, b3e;
  logic        in_wait, done;
  logic [4:0]  judge_st;

  // credential lengths clamped to slot and limit
  assign ulen_c = (user_length > CRED_EFF) ? CRED_EFF : user_length;
  assign plen_c = (pass_length > CRED_EFF) ? CRED_EFF : pass_length;

  assign stat.out_free = !out_valid || out_ready;
  assign stat.need_pw  = require_password;
  assign stat.ulen     = ulen_c;
  assign stat.plen     = plen_c;

  // request byte for the current run step
  always_comb begin
    unique case (cmd.step)
      E_VER:     tx_byte = SOCKS_VER;
      E_NMETH:   tx_byte = N_METHODS;
      E_METH:    tx_byte = require_password ? METH_PASS : METH_NONE;
      E_AUTHVER: tx_byte = AUTH_VER;
      E_ULEN:    tx_byte = {3'b000, ulen_c};
      E_UBYTE:   tx_byte = cred_mem[{1'b0, cmd.cnt}];
      E_PLEN:    tx_byte = {3'b000, plen_c};
      E_PBYTE:   tx_byte = cred_mem[{1'b1, cmd.cnt}];
      E_CVER:    tx_byte = SOCKS_VER;
      E_CCMD:    tx_byte = CMD_CONNECT;
      E_RSV:     tx_byte = RSV_BYTE;
      E_ATYP:    tx_byte = ATYP_IPV4;
      E_A3:      tx_byte = dest_address[31:24];
      E_A2:      tx_byte = dest_address[23:16];
      E_A1:      tx_byte = dest_address[15:8];
      E_A0:      tx_byte = dest_address[7:0];
      E_P1:      tx_byte = dest_port[15:8];
      E_P0:      tx_byte = dest_port[7:0];
      default:   tx_byte = 8'h00;
    endcase
  end

  // reply gathering with the incoming byte merged in
  assign in_wait   = (phase == PH_METHOD) || (phase == PH_AUTH) || (phase == PH_CONNECT);
  assign size_full = (phase == PH_CONNECT) ? 4'd10 : 4'd2;
  assign cnt_after = rcount + 4'd1;
  assign b0e       = (rcount == 4'd0) ? in_data.data_byte : rb0;
  assign b1e       = (rcount == 4'd1) ? in_data.data_byte : rb1;
  assign b3e       = (rcount == 4'd3) ? in_data.data_byte : rb3;
  assign done      = in_data.read_end || (cnt_after == size_full);

  // reply judgment
  always_comb begin
    judge_st   = ST_OK;
    phase_next = phase;
    case (phase)
      PH_METHOD: begin
        if (cnt_after != 4'd2) begin
          judge_st = ST_BAD_LEN;
        end else if (b0e != SOCKS_VER) begin
          judge_st = ST_NOT_SOCKS5;
        end else if (b1e != METH_NONE && b1e != METH_PASS && b1e != METH_REJECT) begin
          judge_st = ST_UNK_METHOD;
        end else if (require_password) begin
          if (b1e != METH_PASS) begin
            judge_st = (b1e == METH_NONE) ? ST_ANON_ONLY : ST_AUTH_REFUSE;
          end else begin
            phase_next = PH_AUTH;
          end
        end else if (b1e != METH_NONE) begin
          judge_st = ST_AUTH_REQ;
        end else begin
          phase_next = PH_CONNECT;
        end
      end
      PH_AUTH: begin
        if (cnt_after != 4'd2) begin
          judge_st = ST_BAD_LEN;
        end else if (b0e != AUTH_VER) begin
          judge_st = ST_BAD_AUTHVER;
        end else if (b1e != AUTH_OK) begin
          judge_st = ST_AUTH_FAIL;
        end else begin
          phase_next = PH_CONNECT;
        end
      end
      PH_CONNECT: begin
        if (b0e != SOCKS_VER) begin
          judge_st = ST_NOT_SOCKS5;
        end else if (b1e != 8'h00) begin
          judge_st = (b1e <= REP_MAX) ? (ST_REPLY_BASE + b1e[4:0]) : ST_UNK_REPLY;
        end else if (b3e != ATYP_IPV4) begin
          judge_st = ST_NOT_IPV4;
        end else if (cnt_after != 4'd10) begin
          judge_st = ST_BAD_LEN_CON;
        end else begin
          judge_st   = ST_CONNECTED;
          phase_next = PH_CONNECTED;
        end
      end
      default: judge_st = ST_OK;
    endcase
    if (judge_st != ST_OK && judge_st != ST_CONNECTED) begin
      phase_next = PH_CLOSED;
    end
  end

  // credential store, written by load beats
  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.operation == OP_LOAD) begin
      cred_mem[in_data.cred_index] <= in_data.data_byte;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.kind    <= KIND_TX;
      out_data.tx_data <= tx_byte;
      out_data.last    <= (cmd.step == E_P0);
      out_data.status  <= ST_OK;
    end else if (cmd.accept && in_wait && in_data.operation == OP_EOF) begin
      out_data.kind    <= KIND_STATUS;
      out_data.tx_data <= 8'h00;
      out_data.last    <= 1'b1;
      out_data.status  <= ST_EOF;
    end else if (cmd.accept && in_wait && in_data.operation == OP_BYTE) begin
      out_data.kind    <= KIND_STATUS;
      out_data.tx_data <= 8'h00;
      out_data.last    <= 1'b1;
      out_data.status  <= judge_st;
    end
  end

  // control state: config, session phase, reply buffer, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      require_password <= 1'b0;
      dest_address     <= '0;
      dest_port        <= '0;
      user_length      <= '0;
      pass_length      <= '0;
      phase            <= PH_IDLE;
      rcount           <= '0;
      rb0              <= '0;
      rb1              <= '0;
      rb3              <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_REQ_PW:    require_password <= cfg_data[0];
          CFG_DEST_ADDR: dest_address     <= cfg_data;
          CFG_DEST_PORT: dest_port        <= cfg_data[15:0];
          CFG_USER_LEN:  user_length      <= cfg_data[4:0];
          CFG_PASS_LEN:  pass_length      <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end
      if (cmd.accept) begin
        case (in_data.operation)
          OP_START: begin
            phase  <= PH_METHOD;
            rcount <= '0;
            rb0    <= '0;
            rb1    <= '0;
            rb3    <= '0;
          end
          OP_EOF: begin
            if (in_wait) begin
              phase     <= PH_CLOSED;
              rcount    <= '0;
              rb0       <= '0;
              rb1       <= '0;
              rb3       <= '0;
              out_valid <= 1'b1;
            end
          end
          OP_BYTE: begin
            if (in_wait) begin
              if (done) begin
                phase     <= phase_next;
                rcount    <= '0;
                rb0       <= '0;
                rb1       <= '0;
                rb3       <= '0;
                out_valid <= 1'b1;
              end else begin
                rcount <= cnt_after;
                rb0    <= b0e;
                rb1    <= b1e;
                rb3    <= b3e;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/socks5_client_handshake.sv @@
// top level of the socks5 client handshake
//
//   channel  signals                     direction  payload
//   in       in_valid / in_ready         to block   in_data (op, index, byte, read end)
//   out      out_valid / out_ready       from block out_data (kind, tx byte, last, status)
//   cfg      cfg_valid / cfg_ready       to block   cfg_index, cfg_data
//
// a judged reply lands in the output register in the cycle the byte is accepted.
// a start beat emits its request run one byte per cycle from the sequencer while the output
// register is free: 13 bytes without a password, 16 + user + password bytes with one; no input
// beat is taken until the last byte has entered the output register.
// a full output register holds off the input until the beat is taken.
// reset clears config registers, output valid, phase and reply buffer; the credential store is not cleared.
module socks5_client_handshake
  import s5ch_pkg::*;
#(
  parameter int CRED_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  s5ch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_data.operation),
    .stat      (stat),
    .cmd       (cmd)
  );

  s5ch_dpath #(
    .CRED_MAX (CRED_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/socks5_client_handshake_chk.sv @@
// port-level checker for the socks5 client handshake and its bind
`include "socks5_client_handshake_assert.svh"

module socks5_client_handshake_chk
  import s5ch_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  logic tx_beat;
  logic st_beat;
  logic tx_mid;

  // output beat classes
  assign tx_beat = out_valid && out_data.kind == KIND_TX;
  assign st_beat = out_valid && out_data.kind == KIND_STATUS;
  assign tx_mid  = tx_beat && !out_data.last;

  // a stalled output beat holds
  `S5CH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // status beats close with last and carry no byte
  `S5CH_ASSERT_NOW(a_status_shape, clk, rst, st_beat, out_data.last && out_data.tx_data == 8'h00)

  // transmit beats carry no status
  `S5CH_ASSERT_NOW(a_tx_shape, clk, rst, tx_beat, out_data.status == ST_OK)

  // no input taken while a request run is still going out
  `S5CH_ASSERT_NOW(a_run_blocks_in, clk, rst, tx_mid, !in_ready)

endmodule

bind socks5_client_handshake socks5_client_handshake_chk u_chk (.*);
